// ----- src/kabf_pkg.sv -----
package kabf_pkg;

	localparam int unsigned DtBits   = 16;
	localparam int unsigned CovBits  = 24;
	localparam int unsigned DivSteps = 56;

	localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
	localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_FORCE  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RATE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
		ST_D0, ST_D1, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_OUT
	} kabf_state_t;

	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
		logic signed [32:0] den;
	} kabf_div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quot;
		logic               clip;
	} kabf_div_rsp_t;

	// Saturate to the signed 32-bit range; the top bit flags a clip.
	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		logic [32:0] r;
		if (v > 64'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -64'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	// Round half up, then floor, of a product by 2^DtBits.
	function automatic logic signed [63:0] rnd16(input logic signed [67:0] p);
		logic signed [67:0] t;
		t = p + (68'sd1 <<< (DtBits - 1));
		t = t >>> DtBits;
		return t[63:0];
	endfunction

	function automatic logic signed [63:0] rnd24(input logic signed [67:0] p);
		logic signed [67:0] t;
		t = p + (68'sd1 <<< (CovBits - 1));
		t = t >>> CovBits;
		return t[63:0];
	endfunction

endpackage

// ----- src/kabf_if.sv -----
interface kabf_in_if import kabf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [31:0] measured_angle;
	logic signed [31:0] measured_rate;
	logic        [15:0] time_step;
	modport source (output valid, operation, measured_angle, measured_rate, time_step,
		input ready);
	modport sink (input valid, operation, measured_angle, measured_rate, time_step,
		output ready);
endinterface

interface kabf_out_if import kabf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] filtered_angle;
	logic signed [31:0] estimated_bias;
	logic               saturated;
	modport source (output valid, filtered_angle, estimated_bias, saturated, input ready);
	modport sink (input valid, filtered_angle, estimated_bias, saturated, output ready);
endinterface

interface kabf_cfg_if import kabf_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [30:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/kabf_mul.sv -----
module kabf_mul import kabf_pkg::*; (
	input  logic               clk,
	input  logic signed [35:0] a,
	input  logic signed [31:0] b,
	output logic signed [67:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= 68'(a * b);
	end

endmodule

// ----- src/kabf_div.sv -----
module kabf_div import kabf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  kabf_div_req_t req,
	output kabf_div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [55:0] dq_q;
	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic        neg_q;
	logic        zero_q;
	logic [33:0] rem_sh;
	logic        take;
	logic [55:0] q_next;
	logic [31:0] num_mag;
	logic [32:0] den_mag;

	assign rem_sh  = {rem_q, dq_q[55]};
	assign take    = rem_sh >= {1'b0, den_q};
	assign q_next  = {dq_q[54:0], take};
	assign num_mag = req.num[31] ? 32'(-req.num) : 32'(req.num);
	assign den_mag = req.den[32] ? 33'(-req.den) : 33'(req.den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q   <= {num_mag, 24'd0};
			rem_q  <= '0;
			den_q  <= den_mag;
			neg_q  <= req.num[31] ^ req.den[32];
			zero_q <= (req.den == '0);
		end else if (busy_q) begin
			dq_q  <= q_next;
			rem_q <= take ? 33'(rem_sh - {1'b0, den_q}) : rem_sh[32:0];
		end
	end

	// Sign and clip the magnitude quotient once the last bit is in; a zero divisor gives zero.
	always_comb begin
		rsp.done = done_q;
		rsp.quot = '0;
		rsp.clip = 1'b0;
		if (zero_q) begin
			rsp.quot = '0;
		end else if (neg_q) begin
			if (dq_q > 56'd2147483648) begin
				rsp.quot = 32'h8000_0000;
				rsp.clip = 1'b1;
			end else begin
				rsp.quot = 32'(-dq_q[31:0]);
			end
		end else begin
			if (dq_q > 56'd2147483647) begin
				rsp.quot = 32'h7FFF_FFFF;
				rsp.clip = 1'b1;
			end else begin
				rsp.quot = dq_q[31:0];
			end
		end
	end

endmodule

// ----- src/kalman_angle_bias_filter.sv -----
// Channel  Modport  Transaction
// in       sink     operation, measured_angle, measured_rate, time_step
// out      source   filtered_angle, estimated_bias, saturated
// cfg      sink     index (0 angle noise, 1 bias noise, 2 measurement noise), data
//
// A force transaction presents its result in the cycle after acceptance.
// An update passes through the corrected-rate step, the prediction steps, the
// bit-serial divider for each gain (56 quotient bits), run twice, and the
// correction steps; the shared registered multiplier is used ten times in all.
// The input is ready only while the sequencer is idle; a result held by a
// stalled sink keeps the next input waiting. Reset clears state and covariance
// and loads the noise registers with their default values.
module kalman_angle_bias_filter import kabf_pkg::*; (
	input logic clk,
	input logic arst_n,
	kabf_in_if.sink    in,
	kabf_out_if.source out,
	kabf_cfg_if.sink   cfg
);

	kabf_state_t state_q, state_d;

	logic signed [31:0] angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0] c00_q, c01_q, rate_q, k0_q, k1_q, y_q;
	logic signed [31:0] meas_q, mrate_q;
	logic        [15:0] dt_q;
	logic        [30:0] qa_q, qb_q, r_q;
	logic               sat_q;

	logic signed [35:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [67:0] prod_q;
	kabf_div_req_t      div_req;
	kabf_div_rsp_t      div_rsp;

	logic signed [31:0] dt_s;
	logic signed [63:0] dp11, inner;
	logic [32:0] sat_rate, sat_ang, sat_p01, sat_p10, sat_p00, sat_p11, sat_y;
	logic [32:0] sat_a2, sat_b, sat_c00, sat_c01, sat_c10, sat_c11;

	kabf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));
	kabf_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign dt_s  = {16'd0, dt_q};
	assign dp11  = rnd16(prod_q);
	assign inner = dp11 - 64'(p01_q) - 64'(p10_q) + 64'({1'b0, qa_q});

	assign sat_rate = sat32(64'(mrate_q) - 64'(bias_q));
	assign sat_ang  = sat32(64'(angle_q) + rnd16(prod_q));
	assign sat_p01  = sat32(64'(p01_q) - dp11);
	assign sat_p10  = sat32(64'(p10_q) - dp11);
	assign sat_p00  = sat32(64'(p00_q) + rnd16(prod_q));
	assign sat_p11  = sat32(64'(p11_q) + rnd16(prod_q));
	assign sat_y    = sat32(64'(meas_q) - 64'(angle_q));
	assign sat_a2   = sat32(64'(angle_q) + rnd24(prod_q));
	assign sat_b    = sat32(64'(bias_q) + rnd24(prod_q));
	assign sat_c00  = sat32(64'(p00_q) - rnd24(prod_q));
	assign sat_c01  = sat32(64'(p01_q) - rnd24(prod_q));
	assign sat_c10  = sat32(64'(p10_q) - rnd24(prod_q));
	assign sat_c11  = sat32(64'(p11_q) - rnd24(prod_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in.valid) state_d = (in.operation == OP_FORCE) ? ST_OUT : ST_RATE;
			ST_RATE: state_d = ST_M1;
			ST_M1:   state_d = ST_M2;
			ST_M2:   state_d = ST_M3;
			ST_M3:   state_d = ST_M4;
			ST_M4:   state_d = ST_M5;
			ST_M5:   state_d = ST_D0;
			ST_D0:   if (div_rsp.done) state_d = ST_D1;
			ST_D1:   if (div_rsp.done) state_d = ST_C1;
			ST_C1:   state_d = ST_C2;
			ST_C2:   state_d = ST_C3;
			ST_C3:   state_d = ST_C4;
			ST_C4:   state_d = ST_C5;
			ST_C5:   state_d = ST_C6;
			ST_C6:   state_d = ST_C7;
			ST_C7:   state_d = ST_OUT;
			ST_OUT:  if (out.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshakes, multiplier operands and divider requests per state.
	always_comb begin
		in.ready      = (state_q == ST_IDLE);
		out.valid     = (state_q == ST_OUT);
		mul_a         = '0;
		mul_b         = '0;
		div_req.start = 1'b0;
		div_req.num   = p00_q;
		div_req.den   = 33'(p00_q) + 33'({1'b0, r_q});
		case (state_q)
			ST_M1: begin
				mul_a = 36'(rate_q);
				mul_b = dt_s;
			end
			ST_M2: begin
				mul_a = 36'(p11_q);
				mul_b = dt_s;
			end
			ST_M3: begin
				mul_a = inner[35:0];
				mul_b = dt_s;
			end
			ST_M4: begin
				mul_a = 36'({1'b0, qb_q});
				mul_b = dt_s;
			end
			ST_M5: div_req.start = 1'b1;
			ST_D0: begin
				div_req.num   = p10_q;
				div_req.start = div_rsp.done;
			end
			ST_C1: begin
				mul_a = 36'(k0_q);
				mul_b = y_q;
			end
			ST_C2: begin
				mul_a = 36'(k1_q);
				mul_b = y_q;
			end
			ST_C3: begin
				mul_a = 36'(k0_q);
				mul_b = p00_q;
			end
			ST_C4: begin
				mul_a = 36'(k0_q);
				mul_b = p01_q;
			end
			ST_C5: begin
				mul_a = 36'(k1_q);
				mul_b = p00_q;
			end
			ST_C6: begin
				mul_a = 36'(k1_q);
				mul_b = p01_q;
			end
			default: ;
		endcase
	end

	assign cfg.ready          = 1'b1;
	assign out.filtered_angle = angle_q;
	assign out.estimated_bias = bias_q;
	assign out.saturated      = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			angle_q <= '0;
			bias_q  <= '0;
			p00_q   <= '0;
			p01_q   <= '0;
			p10_q   <= '0;
			p11_q   <= '0;
			sat_q   <= 1'b0;
			qa_q    <= 31'd16777;
			qb_q    <= 31'd50332;
			r_q     <= 31'd503316;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					REG_ANGLE_NOISE: qa_q <= cfg.data;
					REG_BIAS_NOISE:  qb_q <= cfg.data;
					REG_MEAS_NOISE:  r_q  <= cfg.data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (in.valid) begin
					sat_q <= 1'b0;
					if (in.operation == OP_FORCE) angle_q <= in.measured_angle;
				end
				ST_RATE: begin
					rate_q <= sat_rate[31:0];
					sat_q  <= sat_q | sat_rate[32];
				end
				ST_M2: begin
					angle_q <= sat_ang[31:0];
					sat_q   <= sat_q | sat_ang[32];
				end
				ST_M3: begin
					p01_q <= sat_p01[31:0];
					p10_q <= sat_p10[31:0];
					sat_q <= sat_q | sat_p01[32] | sat_p10[32];
				end
				ST_M4: begin
					p00_q <= sat_p00[31:0];
					sat_q <= sat_q | sat_p00[32];
				end
				ST_M5: begin
					p11_q <= sat_p11[31:0];
					y_q   <= sat_y[31:0];
					sat_q <= sat_q | sat_p11[32] | sat_y[32];
				end
				ST_D0: if (div_rsp.done) begin
					k0_q  <= div_rsp.quot;
					sat_q <= sat_q | div_rsp.clip;
				end
				ST_D1: if (div_rsp.done) begin
					k1_q  <= div_rsp.quot;
					sat_q <= sat_q | div_rsp.clip;
				end
				ST_C2: begin
					angle_q <= sat_a2[31:0];
					sat_q   <= sat_q | sat_a2[32];
				end
				ST_C3: begin
					bias_q <= sat_b[31:0];
					sat_q  <= sat_q | sat_b[32];
				end
				ST_C4: begin
					c00_q <= sat_c00[31:0];
					sat_q <= sat_q | sat_c00[32];
				end
				ST_C5: begin
					c01_q <= sat_c01[31:0];
					sat_q <= sat_q | sat_c01[32];
				end
				ST_C6: begin
					p10_q <= sat_c10[31:0];
					sat_q <= sat_q | sat_c10[32];
				end
				ST_C7: begin
					p11_q <= sat_c11[31:0];
					p00_q <= c00_q;
					p01_q <= c01_q;
					sat_q <= sat_q | sat_c11[32];
				end
				default: ;
			endcase
		end
	end

	// Input payload is captured when the transaction is taken.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in.valid) begin
			meas_q  <= in.measured_angle;
			mrate_q <= in.measured_rate;
			dt_q    <= in.time_step;
		end
	end

endmodule
